>>> sv/modexpinv_pkg.sv
// Shared constants for the modular power and inverse core.
`timescale 1ns / 1ps

package modexpinv_pkg;

  // Fixed prime modulus and its width.
  localparam int unsigned ModBits = 30;
  localparam logic [ModBits-1:0] PrimeMod = 30'd998244353;

  // Fermat exponent for the inverse: the prime minus two.
  localparam logic [ModBits-1:0] InvExp = PrimeMod - 30'd2;

  // Barrett factor floor(2^60 / p); it fits in 31 bits.
  localparam int unsigned MuBits = ModBits + 1;
  localparam logic [MuBits-1:0] BarrettMu =
    MuBits'((64'd1 << (2 * ModBits)) / 64'(PrimeMod));

  // Default number of exponent bits that are used in power mode.
  localparam int unsigned ExpBitsDefault = 63;

endpackage : modexpinv_pkg

>>> sv/mod_exponent_inverse_core.sv
// Modular power and Fermat inverse modulo 998244353 with one shared multiplier.
`timescale 1ns / 1ps

// Channel   | Direction | Ports                            | Handshake
// ----------+-----------+----------------------------------+-------------------------------
// command   | in        | mode_i, base_i, exponent_i       | taken when start && !busy
// result    | out       | result_o                         | valid for one cycle on done_o
//
// Each item is worked right to left over the exponent bits. The sequencer runs one
// modular product at a time through a single 31 x 31 bit multiplier: the raw product
// (StMul), the Barrett quotient estimate (StEst) and the quotient times the prime (StQp)
// are formed in turn, and StRed subtracts and corrects. Each product follows the
// decision cycle (StSel), which also ends the item when no exponent bits are left.
// Reset clears the sequencer, the strobe and the result; the datapath registers are
// loaded when an item is taken. The block takes no new item while busy is high, and
// since the receiver cannot stall, the result leaves on done_o in the cycle after the
// decision cycle that finds no exponent bits left.

module mod_exponent_inverse_core #(
  parameter int unsigned EXP_BITS = modexpinv_pkg::ExpBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               mode_i,
  input  logic [modexpinv_pkg::ModBits-1:0]  base_i,
  input  logic [EXP_BITS-1:0]                exponent_i,
  output logic                               done_o,
  output logic [modexpinv_pkg::ModBits-1:0]  result_o
);

  localparam int unsigned ModW = modexpinv_pkg::ModBits;
  localparam int unsigned MuW  = modexpinv_pkg::MuBits;
  localparam int unsigned ProdW = 2 * MuW;
  // The exponent register must hold both the user exponent and the Fermat exponent.
  localparam int unsigned ExpW = (EXP_BITS > ModW) ? EXP_BITS : ModW;

  typedef enum logic [2:0] {
    StIdle,
    StSel,
    StMul,
    StEst,
    StQp,
    StRed
  } state_e;

  state_e state_q;

  // Datapath registers.
  logic [ModW-1:0]  acc_q;
  logic [ModW-1:0]  sq_q;
  logic [ExpW-1:0]  e_q;
  logic             tgt_acc_q;
  logic [ProdW-1:0] mul_q;
  logic [31:0]      xlo_q;

  logic             accept;
  logic [ModW-1:0]  base_red;
  logic [MuW-1:0]   mul_a;
  logic [MuW-1:0]   mul_b;
  logic [ProdW-1:0] mul_prod;
  logic [31:0]      diff;
  logic [31:0]      diff_m1;
  logic [31:0]      diff_m2;
  logic [ModW-1:0]  red_val;

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;

  // The 30-bit base field stays below twice the prime, so one subtraction reduces it.
  assign base_red = (base_i >= modexpinv_pkg::PrimeMod) ?
                    (base_i - modexpinv_pkg::PrimeMod) : base_i;

  // Operand selection for the shared multiplier. In StMul it forms the raw product of
  // two residues, in StEst it scales the top bits of that product by the Barrett
  // factor, and in StQp it multiplies the quotient back by the prime.
  always_comb begin
    unique case (state_q)
      StMul: begin
        mul_a = {1'b0, (tgt_acc_q ? acc_q : sq_q)};
        mul_b = {1'b0, sq_q};
      end
      StEst: begin
        mul_a = mul_q[2*ModW-1:ModW-1];
        mul_b = modexpinv_pkg::BarrettMu;
      end
      StQp: begin
        mul_a = {1'b0, mul_q[2*MuW-2:MuW]};
        mul_b = {1'b0, modexpinv_pkg::PrimeMod};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_prod = {{MuW{1'b0}}, mul_a} * {{MuW{1'b0}}, mul_b};

  // The Barrett quotient is low by at most two, so the true remainder is below three
  // times the prime and fits in 32 bits. Only the low 32 bits of both terms matter.
  assign diff    = xlo_q - mul_q[31:0];
  assign diff_m1 = diff - 32'(modexpinv_pkg::PrimeMod);
  assign diff_m2 = diff - 32'(2 * 64'(modexpinv_pkg::PrimeMod));

  always_comb begin
    priority if (diff >= 32'(2 * 64'(modexpinv_pkg::PrimeMod))) begin
      red_val = diff_m2[ModW-1:0];
    end else if (diff >= 32'(modexpinv_pkg::PrimeMod)) begin
      red_val = diff_m1[ModW-1:0];
    end else begin
      red_val = diff[ModW-1:0];
    end
  end

  // Sequencer with the registered result and strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      done_o   <= 1'b0;
      result_o <= '0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start) begin
            state_q <= StSel;
          end
        end
        StSel: begin
          if (e_q == '0) begin
            result_o <= acc_q;
            done_o   <= 1'b1;
            state_q  <= StIdle;
          end else begin
            state_q <= StMul;
          end
        end
        StMul: state_q <= StEst;
        StEst: state_q <= StQp;
        StQp:  state_q <= StRed;
        StRed: state_q <= StSel;
        default: state_q <= StIdle;
      endcase
    end
  end

  // Datapath. The decision cycle either folds the current square into the accumulator
  // for a set low bit, or squares and moves to the next exponent bit.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q <= ModW'(1);
      sq_q  <= base_red;
      e_q   <= mode_i ? ExpW'(modexpinv_pkg::InvExp) : ExpW'(exponent_i);
    end
    if (state_q == StSel && e_q != '0) begin
      if (e_q[0]) begin
        tgt_acc_q <= 1'b1;
        e_q[0]    <= 1'b0;
      end else begin
        tgt_acc_q <= 1'b0;
        e_q       <= e_q >> 1;
      end
    end
    if (state_q == StMul || state_q == StEst || state_q == StQp) begin
      mul_q <= mul_prod;
    end
    if (state_q == StEst) begin
      xlo_q <= mul_q[31:0];
    end
    if (state_q == StRed) begin
      if (tgt_acc_q) begin
        acc_q <= red_val;
      end else begin
        sq_q <= red_val;
      end
    end
  end

  // A taken item makes the core busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy)
    else $error("core not busy after taking an item");

  // While the strobe is high the core is already idle and free for a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while still busy");

  // The strobe lasts a single cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // The Barrett remainder before correction must lie below three times the prime.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == StRed) |-> (diff < 32'(3 * 64'(modexpinv_pkg::PrimeMod))))
    else $error("Barrett remainder out of range");

  // Every result is a reduced residue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> (result_o < modexpinv_pkg::PrimeMod))
    else $error("result not reduced");

endmodule : mod_exponent_inverse_core

>>> tb/sv/mod_exponent_inverse_checker.sv
// Checker that predicts and compares the results of the modular power core.
`timescale 1ns / 1ps

module mod_exponent_inverse_checker #(
  parameter int unsigned ExpBits = modexpinv_pkg::ExpBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_i,
  input  logic                              mode_i,
  input  logic [modexpinv_pkg::ModBits-1:0] base_i,
  input  logic [ExpBits-1:0]                exponent_i,
  input  logic                              done_i,
  input  logic [modexpinv_pkg::ModBits-1:0] result_i,
  output int unsigned                       mismatch_count_o,
  output int unsigned                       pending_o
);

  typedef logic [modexpinv_pkg::ModBits-1:0] residue_t;

  residue_t    expected_residues[$];
  int unsigned mismatch_count = 0;

  // Right-to-left square and multiply; every product of two residues fits in 64 bits.
  function automatic residue_t mod_pow_prime(logic mode, residue_t base,
                                             logic [ExpBits-1:0] exponent);
    bit [63:0] acc;
    bit [63:0] sq;
    bit [63:0] e;
    bit [63:0] prime;
    prime = 64'(modexpinv_pkg::PrimeMod);
    acc   = 64'd1;
    sq    = 64'(base) % prime;
    e     = mode ? 64'(modexpinv_pkg::InvExp) : 64'(exponent);
    for (int k = 0; k < 64; k++) begin
      if (e[k]) acc = (acc * sq) % prime;
      sq = (sq * sq) % prime;
    end
    return residue_t'(acc);
  endfunction

  task automatic report_mismatch(string what, residue_t seen, residue_t wanted);
    $display("%0t ns: %s: result %0d, expected %0d", $time, what, seen, wanted);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    residue_t wanted;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        expected_residues = {expected_residues, mod_pow_prime(mode_i, base_i, exponent_i)};
      end
      if (done_i) begin
        if (expected_residues.size() == 0) begin
          report_mismatch("result with no item outstanding", result_i, '0);
        end else begin
          wanted = expected_residues.pop_front();
          if (result_i !== wanted) report_mismatch("wrong residue", result_i, wanted);
        end
      end
    end
    pending_o <= $unsigned(expected_residues.size());
  end

  assign mismatch_count_o = mismatch_count;

endmodule : mod_exponent_inverse_checker

>>> tb/sv/tb_top.sv
// Top of the testbench: clock, reset, item stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned ModBits = modexpinv_pkg::ModBits;
  localparam logic [ModBits-1:0] PrimeMod = modexpinv_pkg::PrimeMod;
  localparam logic [ModBits-1:0] InvExp = modexpinv_pkg::InvExp;
  localparam int unsigned ExpBits = modexpinv_pkg::ExpBitsDefault;
  // Idle cycles allowed with nothing taken and nothing returned. The slowest item
  // has an all-ones 63-bit exponent, and the sender may add a gap before an item.
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems = 1000;
  localparam logic [ModBits-1:0] TopResidue = PrimeMod - 30'd1;
  localparam logic [ModBits-1:0] MaxBase = '1;
  localparam logic [ExpBits-1:0] AllOnesExp = '1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                mode_i;
  logic [ModBits-1:0]  base_i;
  logic [ExpBits-1:0]  exponent_i;
  logic                done_o;
  logic [ModBits-1:0]  result_o;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_cycles = 0;
  int unsigned power_items;
  int unsigned inverse_items;
  int unsigned results_seen = 0;
  bit          quiet_stretch;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  mod_exponent_inverse_core #(
    .EXP_BITS(ExpBits)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .mode_i    (mode_i),
    .base_i    (base_i),
    .exponent_i(exponent_i),
    .done_o    (done_o),
    .result_o  (result_o)
  );

  mod_exponent_inverse_checker #(
    .ExpBits(ExpBits)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .mode_i          (mode_i),
    .base_i          (base_i),
    .exponent_i      (exponent_i),
    .done_i          (done_o),
    .result_i        (result_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_results)
  );

  // The watchdog counts cycles in which no item is taken and no result comes back.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && done_o) results_seen <= results_seen + 1;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit);
    $display("%0t ns: watchdog expired with %0d results outstanding", $time, pending_results);
    $display("end of test: mismatches");
    $finish;
  end

  // Sends one item. Unless we are in a stretch without gaps, start may drop first,
  // with junk on the fields, which the block must ignore. The task returns at the
  // edge where the item was taken, so a following call either keeps start high with
  // new fields or lowers it, one assignment per edge.
  task automatic issue_item(input logic mode, input logic [ModBits-1:0] base,
                            input logic [ExpBits-1:0] exponent);
    int unsigned gap;
    gap = quiet_stretch ? 0 : $urandom_range(3, 0);
    if (gap > 0) begin
      start      <= 1'b0;
      mode_i     <= 1'($urandom);
      base_i     <= ModBits'($urandom);
      exponent_i <= ExpBits'({$urandom, $urandom});
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= mode;
    base_i     <= base;
    exponent_i <= exponent;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (mode) inverse_items++;
    else power_items++;
  endtask

  // An exponent whose highest set bit sits at a random position, so that most items
  // stay short; one in eight uses the full width with random content.
  function automatic logic [ExpBits-1:0] draw_exponent();
    logic [63:0]  raw;
    int unsigned  len;
    raw = {$urandom, $urandom};
    if ($urandom_range(7, 0) == 0) return ExpBits'(raw);
    len = $urandom_range(ExpBits, 0);
    if (len == 0) return '0;
    raw = raw & ((64'd1 << len) - 64'd1);
    raw[len-1] = 1'b1;
    return ExpBits'(raw);
  endfunction

  // Bases: mostly residues below the prime, with the edges and the unreduced values
  // from the prime up to the top of the 30-bit field mixed in.
  function automatic logic [ModBits-1:0] draw_base();
    case ($urandom_range(9, 0))
      0: begin
        case ($urandom_range(3, 0))
          0:       return '0;
          1:       return ModBits'(1);
          2:       return TopResidue;
          default: return PrimeMod;
        endcase
      end
      1:       return ModBits'($urandom_range(32'(MaxBase), 32'(PrimeMod)));
      default: return ModBits'($urandom_range(32'(TopResidue), 0));
    endcase
  endfunction

  initial begin
    logic m;
    rst_ni        = 1'b0;
    start         = 1'b0;
    mode_i        = 1'b0;
    base_i        = '0;
    exponent_i    = '0;
    power_items   = 0;
    inverse_items = 0;
    quiet_stretch = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items: zero exponent, zero and unreduced bases, the inverse of zero
    // and of the prime itself, full-width exponents and the Fermat identities.
    issue_item(1'b0, '0, '0);
    issue_item(1'b0, ModBits'(12345), '0);
    issue_item(1'b0, '0, ExpBits'(1));
    issue_item(1'b0, TopResidue, AllOnesExp);
    issue_item(1'b0, MaxBase, AllOnesExp);
    issue_item(1'b0, PrimeMod, ExpBits'(5));
    issue_item(1'b0, PrimeMod + 30'd1, AllOnesExp);
    issue_item(1'b0, ModBits'(2), ExpBits'(1));
    issue_item(1'b0, ModBits'(2), ExpBits'(1) << (ExpBits - 1));
    issue_item(1'b0, ModBits'(3), ExpBits'(TopResidue));
    issue_item(1'b0, ModBits'(12345), ExpBits'(InvExp));
    issue_item(1'b0, TopResidue, ExpBits'(2));
    issue_item(1'b1, '0, '0);
    issue_item(1'b1, PrimeMod, AllOnesExp);
    issue_item(1'b1, ModBits'(1), '0);
    issue_item(1'b1, TopResidue, ExpBits'(7));
    issue_item(1'b1, MaxBase, AllOnesExp);
    issue_item(1'b1, ModBits'(2), '0);
    issue_item(1'b1, ModBits'(3), AllOnesExp);

    // Random items in stretches of forty, each stretch chosen at random to run with or without gaps before the items.
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 40 == 0) quiet_stretch = ($urandom_range(2, 0) == 0);
      m = ($urandom_range(3, 0) == 0);
      issue_item(m, draw_base(), draw_exponent());
    end
    start <= 1'b0;

    // Let the checker record the last item, wait for the last results to drain, then
    // let the block sit quiet before the verdict.
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d power items and %0d inverse items; %0d results came back.",
             power_items, inverse_items, results_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : tb_top
